// ===== src/projective_ratio_to_unit_circle_assert.svh =====
// Assertion macros shared by the checker of projective_ratio_to_unit_circle
`ifndef PROJECTIVE_RATIO_TO_UNIT_CIRCLE_ASSERT_SVH
`define PROJECTIVE_RATIO_TO_UNIT_CIRCLE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define PRTUC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define PRTUC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/prtuc_pkg.sv =====
// Types and constants of the projective ratio to unit circle block
package prtuc_pkg;

    localparam int NUM_W    = 32;
    localparam int OUT_W    = 18;
    localparam int STATUS_W = 2;
    localparam int LIMIT_W  = 16;
    localparam int MUL_W    = 16;
    localparam int FRAC_BITS = 16;
    localparam int QUO_W    = FRAC_BITS + 1;

    localparam logic [LIMIT_W-1:0] LIMIT_MIN   = 16'd1;
    localparam logic [LIMIT_W-1:0] LIMIT_MAX   = 16'd46340;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd32767;

    localparam logic [STATUS_W-1:0] STATUS_ZERO = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_DIV  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_INF  = 2'd2;

    localparam logic signed [OUT_W-1:0] Q16_ONE = 18'sd65536;

endpackage

// ===== src/prtuc_if.sv =====
// Channel interfaces: ratio input, circle point output, limit register write
interface prtuc_in_if
    import prtuc_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic signed [NUM_W-1:0] ratio_num;
    logic signed [NUM_W-1:0] ratio_den;

    modport source (output valid, output ratio_num, output ratio_den, input ready);
    modport sink   (input valid, input ratio_num, input ratio_den, output ready);
endinterface

interface prtuc_out_if
    import prtuc_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic signed [OUT_W-1:0]    x_q16;
    logic signed [OUT_W-1:0]    y_q16;
    logic        [STATUS_W-1:0] status;

    modport source (output valid, output x_q16, output y_q16, output status, input ready);
    modport sink   (input valid, input x_q16, input y_q16, input status, output ready);
endinterface

interface prtuc_cfg_if
    import prtuc_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [LIMIT_W-1:0] magnitude_limit;

    modport source (output valid, output magnitude_limit, input ready);
    modport sink   (input valid, input magnitude_limit, output ready);
endinterface

// ===== src/prtuc_ser_mul.sv =====
// Bit-serial 16x16 unsigned multiplier, one multiplier bit per cycle
module prtuc_ser_mul
    import prtuc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [MUL_W-1:0]     a,
    input  logic [MUL_W-1:0]     b,
    output logic                 done,
    output logic [2*MUL_W-1:0]   product
);

    localparam int CNT_W = $clog2(MUL_W);

    logic [MUL_W-1:0]   mcand_reg, mcand_next;
    logic [2*MUL_W-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [MUL_W:0]     sum;

    // upper half plus selected multiplicand; lower half still holds multiplier bits
    assign sum = {1'b0, acc_reg[2*MUL_W-1:MUL_W]} + {1'b0, (acc_reg[0] ? mcand_reg : '0)};

    always_comb
    begin
        mcand_next = mcand_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start)
        begin
            mcand_next = a;
            acc_next   = {{MUL_W{1'b0}}, b};
            cnt_next   = '0;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = {sum, acc_reg[MUL_W-1:1]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(MUL_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg <= mcand_next;
        acc_reg   <= acc_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

// ===== src/prtuc_ser_div.sv =====
// Restoring divider, one Q16 quotient bit per cycle, signed result
module prtuc_ser_div
    import prtuc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic                    neg,
    input  logic [NUM_W-1:0]        num,
    input  logic [NUM_W-1:0]        den,
    output logic                    done,
    output logic signed [OUT_W-1:0] quot
);

    localparam int CNT_W = $clog2(QUO_W);

    logic [NUM_W-1:0] rem_reg, rem_next;
    logic [QUO_W-1:0] bits_reg, bits_next;
    logic [QUO_W-1:0] q_reg, q_next;
    logic [NUM_W-1:0] den_reg, den_next;
    logic             neg_reg, neg_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [NUM_W:0]   shifted;
    logic [NUM_W:0]   trial;
    logic             fits;
    logic [OUT_W-1:0] q_ext;

    assign shifted = {rem_reg, bits_reg[QUO_W-1]};
    assign trial   = shifted - {1'b0, den_reg};
    assign fits    = !trial[NUM_W];

    always_comb
    begin
        rem_next  = rem_reg;
        bits_next = bits_reg;
        q_next    = q_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            // dividend is num << FRAC_BITS; top bits already below den
            rem_next  = {1'b0, num[NUM_W-1:1]};
            bits_next = {num[0], {(QUO_W-1){1'b0}}};
            q_next    = '0;
            den_next  = den;
            neg_next  = neg;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? trial[NUM_W-1:0] : shifted[NUM_W-1:0];
            bits_next = {bits_reg[QUO_W-2:0], 1'b0};
            q_next    = {q_reg[QUO_W-2:0], fits};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(QUO_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        bits_reg <= bits_next;
        q_reg    <= q_next;
        den_reg  <= den_next;
        neg_reg  <= neg_next;
    end

    assign q_ext = {{(OUT_W-QUO_W){1'b0}}, q_reg};
    assign quot  = neg_reg ? $signed(~q_ext + 1'b1) : $signed(q_ext);
    assign done  = done_reg;

endmodule

// ===== src/projective_ratio_to_unit_circle.sv =====
// Projective ratio (n, d) to Q16 unit circle point: top level
//
// Channels: ratio (sink) carries ratio_num/ratio_den, point (source) carries
// x_q16/y_q16/status, cfg (sink) writes magnitude_limit. All use valid/ready;
// a transfer happens on a rising clk edge with both high. cfg is always ready.
// One item is in work at a time. A (0,0) ratio goes from S_IDLE straight to
// S_DONE and from there into the output register. Otherwise the item passes
// S_HALVE (h = 0 to 31 halving steps, one per cycle), S_MUL (the bit-serial
// multipliers, 16 bit steps plus done), S_PREP (forms the numerators), S_DIV
// (two restoring dividers running side by side, 17 quotient bits plus done)
// and S_DONE, which loads the output register. The next ratio is taken once
// the core is back in S_IDLE after that load.
// ratio.ready is high only while the core is idle; it is taken again even
// while a finished point still waits in the output register.
// If point stalls, the result stays in the output register and the core holds
// its next result until that register frees up.
// Reset (rst_n low, asynchronous) empties the core and output register and
// sets magnitude_limit to 32767. Limits of 0 act as 1, above 46340 as 46340.
module projective_ratio_to_unit_circle
    import prtuc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    prtuc_cfg_if.sink    cfg,
    prtuc_in_if.sink     ratio,
    prtuc_out_if.source  point
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_HALVE = 6'b000010,
        S_MUL   = 6'b000100,
        S_PREP  = 6'b001000,
        S_DIV   = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [LIMIT_W-1:0]  limit_reg, limit_next;
    logic [LIMIT_W-1:0]  lim_eff;
    logic [NUM_W-1:0]    mn_reg, mn_next;
    logic [NUM_W-1:0]    md_reg, md_next;
    logic [NUM_W-1:0]    mx_reg, mx_next;
    logic                yneg_reg, yneg_next;
    logic [STATUS_W-1:0] stat_reg, stat_next;

    logic                    out_valid_reg, out_valid_next;
    logic signed [OUT_W-1:0] x_reg, x_next;
    logic signed [OUT_W-1:0] y_reg, y_next;
    logic [STATUS_W-1:0]     out_stat_reg, out_stat_next;

    logic [NUM_W-1:0] rn_u, rd_u, mn_in, md_in;
    logic [NUM_W:0]   mn_inc, md_inc, mx_inc;
    logic             over;
    logic             accept, load;

    logic                    mul_start, nn_done, dd_done, nd_done, mul_done;
    logic [2*MUL_W-1:0]      nn_prod, dd_prod, nd_prod;
    logic                    div_start, x_done, y_done, div_done;
    logic [NUM_W-1:0]        den, xnum, ynum;
    logic                    xneg;
    logic signed [OUT_W-1:0] x_quot, y_quot;

    // limit register and its clamp
    assign cfg.ready  = 1'b1;
    assign limit_next = (cfg.valid) ? cfg.magnitude_limit : limit_reg;
    assign lim_eff    = (limit_reg < LIMIT_MIN) ? LIMIT_MIN :
                        (limit_reg > LIMIT_MAX) ? LIMIT_MAX : limit_reg;

    // input magnitudes
    assign rn_u  = ratio.ratio_num;
    assign rd_u  = ratio.ratio_den;
    assign mn_in = rn_u[NUM_W-1] ? (~rn_u + 1'b1) : rn_u;
    assign md_in = rd_u[NUM_W-1] ? (~rd_u + 1'b1) : rd_u;

    // halving with the magnitude rounded up
    assign mn_inc = {1'b0, mn_reg} + 1'b1;
    assign md_inc = {1'b0, md_reg} + 1'b1;
    assign mx_inc = {1'b0, mx_reg} + 1'b1;
    assign over   = mx_reg > {{(NUM_W-LIMIT_W){1'b0}}, lim_eff};

    assign ratio.ready = (state_reg == S_IDLE);
    assign accept      = ratio.valid && ratio.ready;
    assign load        = (state_reg == S_DONE) && (!out_valid_reg || point.ready);

    assign mul_start = (state_reg == S_HALVE) && !over;
    assign mul_done  = nn_done && dd_done && nd_done;
    assign div_start = (state_reg == S_PREP);
    assign div_done  = x_done && y_done;

    // numerators and denominator from the squared magnitudes
    assign den  = nn_prod + dd_prod;
    assign xneg = nn_prod < dd_prod;
    assign xnum = xneg ? (dd_prod - nn_prod) : (nn_prod - dd_prod);
    assign ynum = {nd_prod[NUM_W-2:0], 1'b0};

    always_comb
    begin
        state_next = state_reg;
        mn_next    = mn_reg;
        md_next    = md_reg;
        mx_next    = mx_reg;
        yneg_next  = yneg_reg;
        stat_next  = stat_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    mn_next   = mn_in;
                    md_next   = md_in;
                    mx_next   = (mn_in > md_in) ? mn_in : md_in;
                    yneg_next = rn_u[NUM_W-1] ^ rd_u[NUM_W-1];
                    if (rn_u == '0 && rd_u == '0)
                    begin
                        stat_next  = STATUS_ZERO;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        stat_next  = (rd_u == '0) ? STATUS_INF : STATUS_DIV;
                        state_next = S_HALVE;
                    end
                end
            end
            S_HALVE:
            begin
                if (over)
                begin
                    mn_next = mn_inc[NUM_W:1];
                    md_next = md_inc[NUM_W:1];
                    mx_next = mx_inc[NUM_W:1];
                end
                else
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                if (mul_done)
                begin
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        out_stat_next  = out_stat_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            out_stat_next  = stat_reg;
            if (stat_reg == STATUS_ZERO)
            begin
                x_next = '0;
                y_next = '0;
            end
            else
            begin
                x_next = x_quot;
                y_next = y_quot;
            end
        end
        else if (point.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            limit_reg     <= LIMIT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            limit_reg     <= limit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mn_reg       <= mn_next;
        md_reg       <= md_next;
        mx_reg       <= mx_next;
        yneg_reg     <= yneg_next;
        stat_reg     <= stat_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        out_stat_reg <= out_stat_next;
    end

    prtuc_ser_mul u_mul_nn (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mn_reg[MUL_W-1:0]),
        .b       (mn_reg[MUL_W-1:0]),
        .done    (nn_done),
        .product (nn_prod)
    );

    prtuc_ser_mul u_mul_dd (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (md_reg[MUL_W-1:0]),
        .b       (md_reg[MUL_W-1:0]),
        .done    (dd_done),
        .product (dd_prod)
    );

    prtuc_ser_mul u_mul_nd (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mn_reg[MUL_W-1:0]),
        .b       (md_reg[MUL_W-1:0]),
        .done    (nd_done),
        .product (nd_prod)
    );

    prtuc_ser_div u_div_x (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .neg   (xneg),
        .num   (xnum),
        .den   (den),
        .done  (x_done),
        .quot  (x_quot)
    );

    prtuc_ser_div u_div_y (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .neg   (yneg_reg),
        .num   (ynum),
        .den   (den),
        .done  (y_done),
        .quot  (y_quot)
    );

    assign point.valid  = out_valid_reg;
    assign point.x_q16  = x_reg;
    assign point.y_q16  = y_reg;
    assign point.status = out_stat_reg;

endmodule

// ===== src/prtuc_checker.sv =====
// Port-level checker for projective_ratio_to_unit_circle, with its bind
`include "projective_ratio_to_unit_circle_assert.svh"

module prtuc_checker
    import prtuc_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    point_valid,
    input logic                    point_ready,
    input logic signed [OUT_W-1:0] x_q16,
    input logic signed [OUT_W-1:0] y_q16,
    input logic [STATUS_W-1:0]     status
);

    `PRTUC_ASSERT_NEXT(a_point_hold, point_valid && !point_ready, point_valid && $stable(x_q16) && $stable(y_q16) && $stable(status), "point changed while stalled")

    `PRTUC_ASSERT_NOW(a_zero_point, point_valid && status == STATUS_ZERO, x_q16 == '0 && y_q16 == '0, "zero ratio gave nonzero point")

    `PRTUC_ASSERT_NOW(a_inf_point, point_valid && status == STATUS_INF, x_q16 == Q16_ONE && y_q16 == '0, "zero denominator point is not (1,0)")

    `PRTUC_ASSERT_NOW(a_range, point_valid, x_q16 <= Q16_ONE && x_q16 >= -Q16_ONE && y_q16 <= Q16_ONE && y_q16 >= -Q16_ONE, "point outside unit range")

endmodule

bind projective_ratio_to_unit_circle prtuc_checker u_prtuc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .point_valid (point.valid),
    .point_ready (point.ready),
    .x_q16       (point.x_q16),
    .y_q16       (point.y_q16),
    .status      (point.status)
);
